// ----- src/ppbdw_pkg.sv -----
// ----------------------------------------------------------------------------
// ppbdw_pkg
// Types and constants of the ping-pong burst DMA writer.
// ----------------------------------------------------------------------------
package ppbdw_pkg;

  localparam int CHANNELS           = 8;
  localparam int HALF_BUFFER_BURSTS = 200;
  localparam int BURST_WORDS        = 2 * CHANNELS;
  localparam int FULL_BUFFER_BURSTS = 2 * HALF_BUFFER_BURSTS;

  localparam int ADDR_W  = 30;
  localparam int WORD_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int IDX_W   = (BURST_WORDS > 1) ? $clog2(BURST_WORDS) : 1;
  localparam int POS_W   = $clog2(FULL_BUFFER_BURSTS);
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0] RAM_BASE_RESET    = ADDR_W'(32'h1F40_0004 / 4);
  localparam logic [ADDR_W-1:0] STATUS_ADDR_RESET = ADDR_W'(32'h1F40_0000 / 4);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAM_BASE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_ADDR = CFG_IDX_W'(1);

  // status word values
  localparam logic [WORD_W-1:0] STATUS_FIRST_HALF = WORD_W'(0);
  localparam logic [WORD_W-1:0] STATUS_WRAP       = WORD_W'(1);

  typedef struct packed {
    logic [WORD_W-1:0] sample_word;
    logic [SLOT_W-1:0] slot_index;
    logic              end_of_burst;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_word_addr;
    logic [WORD_W-1:0] write_value;
    logic              is_status_write;
    logic              irq_level;
    logic              run_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DRAIN  = 3'b010,
    ST_STATUS = 3'b100
  } state_e;

endpackage

// ----- src/ping_pong_burst_dma_writer.sv -----
// ----------------------------------------------------------------------------
// ping_pong_burst_dma_writer
// Collects sample words in a burst buffer memory and drains each finished
// burst as a run of memory writes into a ping-pong region, with a status
// write and interrupt level when a half of the region is complete.
// ----------------------------------------------------------------------------
//  channel | signals                           | direction | payload
//  --------+-----------------------------------+-----------+----------------
//  in      | in_valid_i / in_ready_o           | sink      | in_item_t
//  out     | out_valid_o / out_ready_i         | source    | out_item_t
//  cfg     | cfg_valid_i / cfg_ready_o         | sink      | index + data
//
//  a beat that does not end a burst is written to the buffer, beats stream back to back while idle
//  an end-of-burst beat starts a drain of BURST_WORDS writes (plus a status
//  write): one buffer memory read per write, output register in the loop
//  reset clears the buffer through per-slot valid bits, no clearing pass
//  a stalled output holds the drain; input is refused until the drain ends
// ----------------------------------------------------------------------------
module ping_pong_burst_dma_writer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  ppbdw_pkg::in_item_t                   in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output ppbdw_pkg::out_item_t                  out_item_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ppbdw_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [31:0]                           cfg_data_i
);

  localparam int AW = ppbdw_pkg::ADDR_W;
  localparam int WW = ppbdw_pkg::WORD_W;
  localparam int IW = ppbdw_pkg::IDX_W;
  localparam int PW = ppbdw_pkg::POS_W;
  localparam int SW = ppbdw_pkg::SLOT_W;

  ppbdw_pkg::state_e state_q, state_d;

  logic [WW-1:0] slot_mem [ppbdw_pkg::BURST_WORDS];
  logic [ppbdw_pkg::BURST_WORDS-1:0] slot_vld_q;

  logic [AW-1:0] ram_base_q, status_addr_q;
  logic [PW-1:0] pos_q, pos_d;
  logic [AW-1:0] base_q;
  logic [IW-1:0] idx_q;
  logic          status_q, status_wrap_q, irq_q;

  logic                 out_valid_q;
  ppbdw_pkg::out_item_t out_q;

  logic          in_acc, wr_en, load, last_idx;
  logic [SW+IW-1:0] slot_wide;
  logic [IW-1:0] wr_idx;
  logic [PW-1:0] pos_inc;
  logic [AW-1:0] pos_off;

  assign in_ready_o  = (state_q == ppbdw_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign in_acc    = in_valid_i && in_ready_o;
  assign slot_wide = (SW + IW)'(in_item_i.slot_index);
  assign wr_idx    = slot_wide[IW-1:0];
  assign wr_en     = in_acc && (32'(in_item_i.slot_index) < 32'(ppbdw_pkg::BURST_WORDS));

  assign pos_inc  = (32'(pos_q) == 32'(ppbdw_pkg::FULL_BUFFER_BURSTS - 1)) ? '0 : pos_q + 1'b1;
  assign pos_off  = AW'(32'(pos_q) * 32'(ppbdw_pkg::BURST_WORDS));

  // output register free, or freed this cycle
  assign load     = (state_q != ppbdw_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign last_idx = (idx_q == IW'(ppbdw_pkg::BURST_WORDS - 1));

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    unique case (state_q)
      ppbdw_pkg::ST_IDLE: begin
        if (in_acc && in_item_i.end_of_burst) begin
          state_d = ppbdw_pkg::ST_DRAIN;
          pos_d   = pos_inc;
        end
      end
      ppbdw_pkg::ST_DRAIN: begin
        if (load && last_idx) begin
          state_d = status_q ? ppbdw_pkg::ST_STATUS : ppbdw_pkg::ST_IDLE;
        end
      end
      ppbdw_pkg::ST_STATUS: begin
        if (load) begin
          state_d = ppbdw_pkg::ST_IDLE;
        end
      end
      default: state_d = ppbdw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ppbdw_pkg::ST_IDLE;
      pos_q         <= '0;
      irq_q         <= 1'b0;
      status_q      <= 1'b0;
      status_wrap_q <= 1'b0;
      idx_q         <= '0;
      slot_vld_q    <= '0;
      out_valid_q   <= 1'b0;
      ram_base_q    <= ppbdw_pkg::RAM_BASE_RESET;
      status_addr_q <= ppbdw_pkg::STATUS_ADDR_RESET;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (wr_en) begin
        slot_vld_q[wr_idx] <= 1'b1;
      end
      if (in_acc && in_item_i.end_of_burst) begin
        idx_q         <= '0;
        status_q      <= (pos_inc == '0) || (32'(pos_inc) == 32'(ppbdw_pkg::HALF_BUFFER_BURSTS));
        status_wrap_q <= (pos_inc == '0);
        irq_q         <= (pos_inc == '0) || (32'(pos_inc) == 32'(ppbdw_pkg::HALF_BUFFER_BURSTS));
      end else if (load && state_q == ppbdw_pkg::ST_DRAIN) begin
        idx_q <= idx_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ppbdw_pkg::REG_RAM_BASE) begin
          ram_base_q <= cfg_data_i[AW-1:0];
        end else if (cfg_index_i == ppbdw_pkg::REG_STATUS_ADDR) begin
          status_addr_q <= cfg_data_i[AW-1:0];
        end
      end
    end
  end

  // buffer memory, burst base and output payload
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_idx] <= in_item_i.sample_word;
    end
    if (in_acc && in_item_i.end_of_burst) begin
      base_q <= ram_base_q + pos_off;
    end
    if (load) begin
      if (state_q == ppbdw_pkg::ST_STATUS) begin
        out_q.write_word_addr <= status_addr_q;
        out_q.write_value     <= status_wrap_q ? ppbdw_pkg::STATUS_WRAP
                                               : ppbdw_pkg::STATUS_FIRST_HALF;
        out_q.is_status_write <= 1'b1;
        out_q.run_end         <= 1'b1;
      end else begin
        out_q.write_word_addr <= base_q + AW'(idx_q);
        out_q.write_value     <= slot_vld_q[idx_q] ? slot_mem[idx_q] : '0;
        out_q.is_status_write <= 1'b0;
        out_q.run_end         <= last_idx && !status_q;
      end
      out_q.irq_level <= irq_q;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < 32'(ppbdw_pkg::FULL_BUFFER_BURSTS))
    else $error("burst position out of range");

  a_last_beat_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.end_of_burst) |=> (state_q == ppbdw_pkg::ST_DRAIN))
    else $error("end of burst did not start a drain");

  a_status_needs_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ppbdw_pkg::ST_STATUS) |-> (status_q && irq_q))
    else $error("status write without half completion");

  a_status_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && state_q == ppbdw_pkg::ST_STATUS)
      |=> (out_valid_q && out_q.is_status_write && out_q.run_end))
    else $error("status item malformed");

  a_no_input_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ppbdw_pkg::ST_DRAIN && !load) |=> $stable(idx_q))
    else $error("drain index moved without a write");

endmodule

// ----- test/ping_pong_burst_dma_writer_tb.sv -----
// ----------------------------------------------------------------------------
// ping_pong_burst_dma_writer_tb
// Streams sample beats into the burst DMA writer and checks every memory
// write it emits against a local model of the burst buffer, burst position
// and interrupt level. Runs a short directed set, then random bursts under
// three idling mixes, with base and status addresses moved between phases.
// ----------------------------------------------------------------------------
module ping_pong_burst_dma_writer_tb;

  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_TAIL  = 20;
  localparam int RANDOM_ITEMS = 450;

  // indexes with no register behind them
  localparam logic [ppbdw_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = ppbdw_pkg::CFG_IDX_W'(2);
  localparam logic [ppbdw_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = ppbdw_pkg::CFG_IDX_W'(3);

  logic                                 clk_i;
  logic                                 rst_n       = 1'b0;
  logic                                 in_valid    = 1'b0;
  ppbdw_pkg::in_item_t                  in_item     = '0;
  logic                                 out_ready   = 1'b0;
  logic                                 cfg_valid   = 1'b0;
  logic [ppbdw_pkg::CFG_IDX_W-1:0]      cfg_index   = '0;
  logic [31:0]                          cfg_data    = '0;
  logic                                 in_ready_o;
  logic                                 out_valid_o;
  ppbdw_pkg::out_item_t                 out_item_o;
  logic                                 cfg_ready_o;

  // burst buffer model and configuration copy
  logic [ppbdw_pkg::WORD_W-1:0] buf_words [ppbdw_pkg::BURST_WORDS];
  logic [ppbdw_pkg::POS_W-1:0]  burst_pos;
  logic                         irq_flag;
  logic [ppbdw_pkg::ADDR_W-1:0] ram_base;
  logic [ppbdw_pkg::ADDR_W-1:0] status_addr;

  ppbdw_pkg::in_item_t  beat_q [$];
  ppbdw_pkg::out_item_t write_q [$];

  int beats_queued   = 0;
  int beats_accepted = 0;
  int bursts_queued  = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  ping_pong_burst_dma_writer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void predict_burst_writes(ppbdw_pkg::in_item_t beat);
    logic [ppbdw_pkg::ADDR_W-1:0] base;
    logic                         status_due;
    logic [ppbdw_pkg::WORD_W-1:0] status_val;
    ppbdw_pkg::out_item_t         wr;
    if (int'(beat.slot_index) < ppbdw_pkg::BURST_WORDS) begin
      buf_words[beat.slot_index] = beat.sample_word;
    end
    if (!beat.end_of_burst) return;
    base = ram_base + ppbdw_pkg::ADDR_W'(int'(burst_pos) * ppbdw_pkg::BURST_WORDS);
    if (int'(burst_pos) + 1 >= ppbdw_pkg::FULL_BUFFER_BURSTS) begin
      burst_pos = '0;
    end else begin
      burst_pos = burst_pos + 1'b1;
    end
    status_due = (burst_pos == '0) ||
                 (int'(burst_pos) == ppbdw_pkg::HALF_BUFFER_BURSTS);
    status_val = (burst_pos == '0) ? ppbdw_pkg::STATUS_WRAP : ppbdw_pkg::STATUS_FIRST_HALF;
    irq_flag   = status_due;
    for (int s = 0; s < ppbdw_pkg::BURST_WORDS; s++) begin
      wr.write_word_addr = base + ppbdw_pkg::ADDR_W'(s);
      wr.write_value     = buf_words[s];
      wr.is_status_write = 1'b0;
      wr.irq_level       = irq_flag;
      wr.run_end         = !status_due && (s == ppbdw_pkg::BURST_WORDS - 1);
      write_q.push_back(wr);
    end
    if (status_due) begin
      wr.write_word_addr = status_addr;
      wr.write_value     = status_val;
      wr.is_status_write = 1'b1;
      wr.irq_level       = irq_flag;
      wr.run_end         = 1'b1;
      write_q.push_back(wr);
    end
  endfunction

  function automatic void push_beat(logic [ppbdw_pkg::WORD_W-1:0] word,
                                    logic [ppbdw_pkg::SLOT_W-1:0] slot,
                                    logic last);
    ppbdw_pkg::in_item_t beat;
    beat.sample_word  = word;
    beat.slot_index   = slot;
    beat.end_of_burst = last;
    beat_q.push_back(beat);
    beats_queued++;
    if (last) bursts_queued++;
  endfunction

  // mostly single-beat bursts so the position wraps; some short and full ones
  function automatic void queue_random_burst();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 94) begin
      push_beat($urandom, ppbdw_pkg::SLOT_W'($urandom_range(15)), 1'b1);
    end else if (pick < 99) begin
      len = $urandom_range(3, 2);
      for (int b = 0; b < len; b++) begin
        push_beat($urandom, ppbdw_pkg::SLOT_W'($urandom_range(15)), b == len - 1);
      end
    end else begin
      for (int s = 0; s < ppbdw_pkg::BURST_WORDS; s++) begin
        push_beat($urandom, ppbdw_pkg::SLOT_W'(s), s == ppbdw_pkg::BURST_WORDS - 1);
      end
    end
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i); while (beats_accepted != beats_queued || write_q.size() != 0);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ppbdw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == ppbdw_pkg::REG_RAM_BASE) begin
      ram_base = data[ppbdw_pkg::ADDR_W-1:0];
    end else if (idx == ppbdw_pkg::REG_STATUS_ADDR) begin
      status_addr = data[ppbdw_pkg::ADDR_W-1:0];
    end
  endtask

  // beat driver
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_burst_writes(in_item);
        beats_accepted++;
      end
      if (!in_valid || in_ready_o) begin
        if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= beat_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // write monitor
  always @(posedge clk_i or negedge rst_n) begin : write_monitor
    ppbdw_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (write_q.size() == 0) begin
          $error("unexpected write: addr %h value %h", out_item_o.write_word_addr,
                 out_item_o.write_value);
          fail_count++;
        end else begin
          want = write_q.pop_front();
          if (out_item_o.write_word_addr !== want.write_word_addr) begin
            $error("write_word_addr: expected %h, got %h", want.write_word_addr,
                   out_item_o.write_word_addr);
            fail_count++;
          end
          if (out_item_o.write_value !== want.write_value) begin
            $error("write_value: expected %h, got %h", want.write_value,
                   out_item_o.write_value);
            fail_count++;
          end
          if (out_item_o.is_status_write !== want.is_status_write) begin
            $error("is_status_write: expected %b, got %b", want.is_status_write,
                   out_item_o.is_status_write);
            fail_count++;
          end
          if (out_item_o.irq_level !== want.irq_level) begin
            $error("irq_level: expected %b, got %b", want.irq_level, out_item_o.irq_level);
            fail_count++;
          end
          if (out_item_o.run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, out_item_o.run_end);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ping_pong_burst_dma_writer_tb failed");
      $finish;
    end
  end

  initial begin
    int first_random;
    for (int s = 0; s < ppbdw_pkg::BURST_WORDS; s++) buf_words[s] = '0;
    burst_pos   = '0;
    irq_flag    = 1'b0;
    ram_base    = ppbdw_pkg::RAM_BASE_RESET;
    status_addr = ppbdw_pkg::STATUS_ADDR_RESET;

    send_idle_pct = 17;
    recv_idle_pct = 53;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;

    // drain of a never-written buffer, then a full burst, overwrite, partial bursts
    push_beat('0, '0, 1'b1);
    for (int s = 0; s < ppbdw_pkg::BURST_WORDS; s++) begin
      push_beat((s == 0) ? 32'hFFFF_FFFF : (s == 1) ? 32'h0 : $urandom,
                ppbdw_pkg::SLOT_W'(s), s == ppbdw_pkg::BURST_WORDS - 1);
    end
    push_beat(32'hDEAD_BEEF, ppbdw_pkg::SLOT_W'(5), 1'b0);
    push_beat(32'h0000_0000, ppbdw_pkg::SLOT_W'(5), 1'b0);
    push_beat(32'hFFFF_FFFF, ppbdw_pkg::SLOT_W'(15), 1'b1);
    push_beat(32'h5A5A_A5A5, ppbdw_pkg::SLOT_W'(10), 1'b1);
    wait_drained();

    // base address at the top of the space so bursts wrap
    write_reg(ppbdw_pkg::REG_RAM_BASE, 32'hFFFF_FFFF);
    write_reg(ppbdw_pkg::REG_STATUS_ADDR, 32'h0000_0000);
    write_reg(REG_UNMAPPED_LO, $urandom);
    first_random = beats_queued;
    while (beats_queued - first_random < 80) queue_random_burst();
    // sender holds off until every write has come out
    wait_drained();
    while (beats_queued - first_random < 160) queue_random_burst();
    wait_drained();

    send_idle_pct = 53;
    recv_idle_pct = 17;
    write_reg(ppbdw_pkg::REG_RAM_BASE, 32'hC000_0000);
    write_reg(ppbdw_pkg::REG_STATUS_ADDR, 32'h7FFF_FFFF);
    write_reg(REG_UNMAPPED_HI, $urandom);
    while (beats_queued - first_random < 310) queue_random_burst();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(ppbdw_pkg::REG_RAM_BASE, $urandom);
    write_reg(ppbdw_pkg::REG_STATUS_ADDR, $urandom);
    while (beats_queued - first_random < RANDOM_ITEMS ||
           bursts_queued <= ppbdw_pkg::FULL_BUFFER_BURSTS + 8) begin
      queue_random_burst();
    end
    wait_drained();

    if (fail_count == 0) begin
      $display("ping_pong_burst_dma_writer_tb passed");
    end else begin
      $display("ping_pong_burst_dma_writer_tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/ppbdw_pkg.sv
src/ping_pong_burst_dma_writer.sv
test/ping_pong_burst_dma_writer_tb.sv
